// ----- rtl/nrlj_pkg.sv -----
// Shared widths, constants and payload types of the non-reciprocal LJ pair force pipeline.
`timescale 1ns / 1ps
package nrlj_pkg;

  localparam int LANES      = 6;   // force on i x/y/z, then force on j x/y/z
  localparam int DISP_W     = 32;
  localparam int KIND_W     = 4;
  localparam int COEF_W     = 48;
  localparam int CHI_W      = 18;
  localparam int CUT_W      = 32;
  localparam int FORCE_W    = 48;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int WEIGHT_W = CHI_W + 1;          // one plus or minus chi
  localparam int PROD_W   = DISP_W + WEIGHT_W;  // displacement times weight
  localparam int WSUM_W   = PROD_W + 1;
  localparam int WABS_W   = PROD_W;
  localparam int RSQ_W    = 2 * DISP_W;
  localparam int R_W      = CUT_W + FRAC_W;     // squared distance inside cutoff
  localparam int REP12_W  = COEF_W + 4;
  localparam int ATT6_W   = COEF_W + 3;
  localparam int SCALE_SH = 96;
  localparam int M_W      = ATT6_W + 3 * R_W + 1;
  localparam int NUM_W    = 384;
  localparam int DEN_W    = 7 * R_W;
  localparam int QUO_W    = FORCE_W;

  localparam int LIMB_W = 32;
  localparam int MUL_W  = 256;
  localparam int LIMBS  = MUL_W / LIMB_W;
  localparam int ROW_W  = MUL_W + LIMB_W;
  localparam int PROD2_W = 2 * MUL_W;

  localparam int FRONT_LAT  = 3;
  localparam int MUL_LAT    = 3;
  localparam int DIV_LAT    = QUO_W + 1;
  localparam int FRONT_HOLD = 3 * MUL_LAT + 1;
  localparam int SIDE_HOLD  = MUL_LAT + DIV_LAT;
  localparam int DEN_HOLD   = MUL_LAT + 1;
  localparam int PIPE_DEPTH = FRONT_LAT + 3 * MUL_LAT + 1 + MUL_LAT + DIV_LAT;

  localparam logic signed [WEIGHT_W-1:0] Q_ONE = WEIGHT_W'(65536);
  localparam logic [KIND_W-1:0] KIND_A = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_B = KIND_W'(1);
  localparam logic [LANES-1:0] OUTER_NEG = LANES'(7);  // lanes of the force on i

  localparam logic [FORCE_W-1:0] POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] NEG_MAX = {1'b1, {(FORCE_W-1){1'b0}}};

  localparam logic [COEF_W-1:0] REPULSIVE_RST   = COEF_W'(262144);
  localparam logic [COEF_W-1:0] ATTRACTIVE_RST  = COEF_W'(262144);
  localparam logic [CUT_W-1:0]  CUTOFF_RST      = CUT_W'(409600);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPULSIVE,
    REG_ATTRACTIVE,
    REG_PARALLEL,
    REG_PERPENDICULAR,
    REG_CUTOFF
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DISP_W-1:0] disp_x;
    logic signed [DISP_W-1:0] disp_y;
    logic signed [DISP_W-1:0] disp_z;
    logic [KIND_W-1:0]        kind_i;
    logic [KIND_W-1:0]        kind_j;
  } in_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_i_x;
    logic signed [FORCE_W-1:0] force_i_y;
    logic signed [FORCE_W-1:0] force_i_z;
    logic signed [FORCE_W-1:0] force_j_x;
    logic signed [FORCE_W-1:0] force_j_y;
    logic signed [FORCE_W-1:0] force_j_z;
    logic                      in_range;
    logic                      saturated;
  } out_t;

  typedef struct packed {
    logic [R_W-1:0]                   rsq;
    logic                             in_range;
    logic                             zero;
    logic [LANES-1:0][WABS_W-1:0]     wabs;
    logic [LANES-1:0]                 wneg;
  } front_t;

  typedef struct packed {
    logic             in_range;
    logic             zero;
    logic [LANES-1:0] neg;
  } side_t;

endpackage

// ----- rtl/nrlj_mul.sv -----
// Three-stage unsigned multiplier built from 32x32 limb products.
`timescale 1ns / 1ps
module nrlj_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic [nrlj_pkg::MUL_W-1:0]        a,
  input  logic [nrlj_pkg::MUL_W-1:0]        b,
  output logic [nrlj_pkg::PROD2_W-1:0]      p
);

  logic [2*nrlj_pkg::LIMB_W-1:0] pp [nrlj_pkg::LIMBS][nrlj_pkg::LIMBS];
  logic [nrlj_pkg::ROW_W-1:0]    row      [nrlj_pkg::LIMBS];
  logic [nrlj_pkg::ROW_W-1:0]    row_next [nrlj_pkg::LIMBS];
  logic [nrlj_pkg::PROD2_W-1:0]  p_next;

  always_comb begin
    for (int i = 0; i < nrlj_pkg::LIMBS; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < nrlj_pkg::LIMBS; j++) begin
        row_next[i] = row_next[i]
                    + ((nrlj_pkg::ROW_W)'(pp[i][j]) << (nrlj_pkg::LIMB_W * j));
      end
    end
    p_next = '0;
    for (int i = 0; i < nrlj_pkg::LIMBS; i++) begin
      p_next = p_next + ((nrlj_pkg::PROD2_W)'(row[i]) << (nrlj_pkg::LIMB_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < nrlj_pkg::LIMBS; i++) begin
        for (int j = 0; j < nrlj_pkg::LIMBS; j++) begin
          pp[i][j] <= a[i*nrlj_pkg::LIMB_W +: nrlj_pkg::LIMB_W]
                    * b[j*nrlj_pkg::LIMB_W +: nrlj_pkg::LIMB_W];
        end
      end
      row <= row_next;
      p   <= p_next;
    end
  end

endmodule

// ----- rtl/nrlj_front.sv -----
// Front stages: magnitudes, pair weights, squared distance, range test, weighted components.
`timescale 1ns / 1ps
module nrlj_front (
  input  logic                                clk,
  input  logic                                en,
  input  nrlj_pkg::in_t                       pair,
  input  logic signed [nrlj_pkg::CHI_W-1:0]   chi_par,
  input  logic signed [nrlj_pkg::CHI_W-1:0]   chi_per,
  input  logic [nrlj_pkg::CUT_W-1:0]          cutoff,
  output nrlj_pkg::front_t                    front
);

  // stage 1
  logic signed [nrlj_pkg::DISP_W-1:0]   s1_x, s1_y, s1_z;
  logic [nrlj_pkg::DISP_W-1:0]          s1_ax, s1_ay, s1_az;
  logic signed [nrlj_pkg::WEIGHT_W-1:0] s1_par [2];
  logic signed [nrlj_pkg::WEIGHT_W-1:0] s1_per [2];
  logic signed [nrlj_pkg::WEIGHT_W-1:0] par_ext, per_ext, w_plus, w_minus, per_neg;
  logic signed [nrlj_pkg::WEIGHT_W-1:0] par_next [2];
  logic signed [nrlj_pkg::WEIGHT_W-1:0] per_next [2];
  // stage 2
  logic [nrlj_pkg::RSQ_W-1:0]           sq_x, sq_y, sq_z;
  logic signed [nrlj_pkg::PROD_W-1:0]   p_xp [2];
  logic signed [nrlj_pkg::PROD_W-1:0]   p_yq [2];
  logic signed [nrlj_pkg::PROD_W-1:0]   p_yp [2];
  logic signed [nrlj_pkg::PROD_W-1:0]   p_xq [2];
  logic signed [nrlj_pkg::PROD_W-1:0]   p_zp [2];
  // stage 3
  logic [nrlj_pkg::RSQ_W-1:0]           rsq_sum;
  logic signed [nrlj_pkg::WSUM_W-1:0]   wsum [nrlj_pkg::LANES];
  nrlj_pkg::front_t                     front_next;

  always_comb begin
    par_ext = (nrlj_pkg::WEIGHT_W)'(chi_par);
    per_ext = (nrlj_pkg::WEIGHT_W)'(chi_per);
    w_plus  = nrlj_pkg::Q_ONE + par_ext;
    w_minus = nrlj_pkg::Q_ONE - par_ext;
    per_neg = -per_ext;
    par_next[0] = nrlj_pkg::Q_ONE;
    per_next[0] = '0;
    par_next[1] = nrlj_pkg::Q_ONE;
    per_next[1] = '0;
    if (pair.kind_i == nrlj_pkg::KIND_A && pair.kind_j == nrlj_pkg::KIND_B) begin
      par_next[0] = w_plus;
      per_next[0] = per_ext;
      par_next[1] = w_minus;
      per_next[1] = per_neg;
    end else if (pair.kind_i == nrlj_pkg::KIND_B && pair.kind_j == nrlj_pkg::KIND_A) begin
      par_next[0] = w_minus;
      per_next[0] = per_neg;
      par_next[1] = w_plus;
      per_next[1] = per_ext;
    end
  end

  always_comb begin
    rsq_sum = sq_x + sq_y + sq_z;
    for (int s = 0; s < 2; s++) begin
      wsum[3*s]   = (nrlj_pkg::WSUM_W)'(p_xp[s]) + (nrlj_pkg::WSUM_W)'(p_yq[s]);
      wsum[3*s+1] = (nrlj_pkg::WSUM_W)'(p_yp[s]) - (nrlj_pkg::WSUM_W)'(p_xq[s]);
      wsum[3*s+2] = (nrlj_pkg::WSUM_W)'(p_zp[s]);
    end
    front_next.rsq      = rsq_sum[nrlj_pkg::R_W-1:0];
    front_next.in_range = rsq_sum < (nrlj_pkg::RSQ_W)'({cutoff, {nrlj_pkg::FRAC_W{1'b0}}});
    front_next.zero     = rsq_sum == '0;
    for (int l = 0; l < nrlj_pkg::LANES; l++) begin
      front_next.wneg[l] = wsum[l][nrlj_pkg::WSUM_W-1];
      front_next.wabs[l] = (nrlj_pkg::WABS_W)'(wsum[l][nrlj_pkg::WSUM_W-1] ? -wsum[l] : wsum[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x  <= pair.disp_x;
      s1_y  <= pair.disp_y;
      s1_z  <= pair.disp_z;
      s1_ax <= pair.disp_x[nrlj_pkg::DISP_W-1] ? ~pair.disp_x + 1'b1 : pair.disp_x;
      s1_ay <= pair.disp_y[nrlj_pkg::DISP_W-1] ? ~pair.disp_y + 1'b1 : pair.disp_y;
      s1_az <= pair.disp_z[nrlj_pkg::DISP_W-1] ? ~pair.disp_z + 1'b1 : pair.disp_z;
      s1_par <= par_next;
      s1_per <= per_next;

      sq_x <= s1_ax * s1_ax;
      sq_y <= s1_ay * s1_ay;
      sq_z <= s1_az * s1_az;
      for (int s = 0; s < 2; s++) begin
        p_xp[s] <= (nrlj_pkg::PROD_W)'(s1_x) * (nrlj_pkg::PROD_W)'(s1_par[s]);
        p_yq[s] <= (nrlj_pkg::PROD_W)'(s1_y) * (nrlj_pkg::PROD_W)'(s1_per[s]);
        p_yp[s] <= (nrlj_pkg::PROD_W)'(s1_y) * (nrlj_pkg::PROD_W)'(s1_par[s]);
        p_xq[s] <= (nrlj_pkg::PROD_W)'(s1_x) * (nrlj_pkg::PROD_W)'(s1_per[s]);
        p_zp[s] <= (nrlj_pkg::PROD_W)'(s1_z) * (nrlj_pkg::PROD_W)'(s1_par[s]);
      end

      front <= front_next;
    end
  end

endmodule

// ----- rtl/nrlj_div.sv -----
// Six-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
`timescale 1ns / 1ps
module nrlj_div (
  input  logic                                                clk,
  input  logic                                                en,
  input  logic [nrlj_pkg::LANES-1:0][nrlj_pkg::NUM_W-1:0]     num,
  input  logic [nrlj_pkg::DEN_W-1:0]                          den,
  output logic [nrlj_pkg::LANES-1:0][nrlj_pkg::QUO_W-1:0]     quo,
  output logic [nrlj_pkg::LANES-1:0]                          over
);

  logic [nrlj_pkg::LANES-1:0][nrlj_pkg::NUM_W-1:0] rem  [nrlj_pkg::QUO_W+1];
  logic [nrlj_pkg::LANES-1:0][nrlj_pkg::QUO_W-1:0] quot [nrlj_pkg::QUO_W+1];
  logic [nrlj_pkg::LANES-1:0]                      ovr  [nrlj_pkg::QUO_W+1];
  logic [nrlj_pkg::DEN_W-1:0]                      dens [nrlj_pkg::QUO_W+1];
  logic [nrlj_pkg::NUM_W:0]                        diff [nrlj_pkg::QUO_W][nrlj_pkg::LANES];
  logic [nrlj_pkg::LANES-1:0]                      take [nrlj_pkg::QUO_W];
  logic [nrlj_pkg::NUM_W-1:0]                      cap;

  // Quotient reaches 2^48 exactly when num >= den * 2^48.
  assign cap = (nrlj_pkg::NUM_W)'(den) << nrlj_pkg::QUO_W;

  always_comb begin
    for (int s = 1; s <= nrlj_pkg::QUO_W; s++) begin
      for (int l = 0; l < nrlj_pkg::LANES; l++) begin
        diff[s-1][l] = {1'b0, rem[s-1][l]}
                     - {1'b0, (nrlj_pkg::NUM_W)'(dens[s-1]) << (nrlj_pkg::QUO_W - s)};
        take[s-1][l] = ~diff[s-1][l][nrlj_pkg::NUM_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dens[0] <= den;
      for (int l = 0; l < nrlj_pkg::LANES; l++) begin
        ovr[0][l]  <= num[l] >= cap;
        rem[0][l]  <= num[l];
        quot[0][l] <= '0;
      end
      for (int s = 1; s <= nrlj_pkg::QUO_W; s++) begin
        dens[s] <= dens[s-1];
        ovr[s]  <= ovr[s-1];
        for (int l = 0; l < nrlj_pkg::LANES; l++) begin
          rem[s][l]  <= take[s-1][l] ? diff[s-1][l][nrlj_pkg::NUM_W-1:0] : rem[s-1][l];
          quot[s][l] <= quot[s-1][l]
                      | ((nrlj_pkg::QUO_W)'(take[s-1][l]) << (nrlj_pkg::QUO_W - s));
        end
      end
    end
  end

  assign quo  = quot[nrlj_pkg::QUO_W];
  assign over = ovr[nrlj_pkg::QUO_W];

endmodule

// ----- rtl/nonreciprocal_lj_pair_force.sv -----
// Top level of the non-reciprocal Lennard-Jones 12-6 pair force pipeline.
// Throughput: one pair per cycle while the skid stage is empty; 65 register stages (front end,
//   four multiplier tiers, one difference stage, 49-step divider per lane).
// Reset (rst, synchronous): clears all valid bits, the skid stage and the config
//   registers to their defaults; the pipeline payload is not cleared.
`timescale 1ns / 1ps
module nonreciprocal_lj_pair_force (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pair_valid,
  output logic                                pair_stall,
  input  nrlj_pkg::in_t                       pair_data,
  output logic                                force_valid,
  input  logic                                force_stall,
  output nrlj_pkg::out_t                      force_data,
  input  logic                                cfg_write,
  input  logic [nrlj_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nrlj_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [nrlj_pkg::COEF_W-1:0]        repulsive;
  logic [nrlj_pkg::COEF_W-1:0]        attractive;
  logic signed [nrlj_pkg::CHI_W-1:0]  chi_par;
  logic signed [nrlj_pkg::CHI_W-1:0]  chi_per;
  logic [nrlj_pkg::CUT_W-1:0]         cutoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      repulsive  <= nrlj_pkg::REPULSIVE_RST;
      attractive <= nrlj_pkg::ATTRACTIVE_RST;
      chi_par    <= '0;
      chi_per    <= '0;
      cutoff     <= nrlj_pkg::CUTOFF_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        nrlj_pkg::REG_REPULSIVE:     repulsive  <= cfg_data[nrlj_pkg::COEF_W-1:0];
        nrlj_pkg::REG_ATTRACTIVE:    attractive <= cfg_data[nrlj_pkg::COEF_W-1:0];
        nrlj_pkg::REG_PARALLEL:      chi_par    <= cfg_data[nrlj_pkg::CHI_W-1:0];
        nrlj_pkg::REG_PERPENDICULAR: chi_per    <= cfg_data[nrlj_pkg::CHI_W-1:0];
        nrlj_pkg::REG_CUTOFF:        cutoff     <= cfg_data[nrlj_pkg::CUT_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline advances together while the skid stage is
  // empty. A result that meets a stalled output parks in the skid stage, which
  // freezes the pipeline on the next cycle. Input stall is thus a register.
  // ---------------------------------------------------------------------------
  logic                                en;
  logic                                skid_valid;
  nrlj_pkg::out_t                      skid_data;
  logic [nrlj_pkg::PIPE_DEPTH-1:0]     vpipe;   // vpipe[k]: valid bit of the item in pipeline stage k
  logic                                pv;

  assign en         = ~skid_valid;
  assign pair_stall = skid_valid;
  assign pv         = vpipe[nrlj_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[nrlj_pkg::PIPE_DEPTH-2:0], pair_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: squared distance, range test, weighted components (3 stages)
  // ---------------------------------------------------------------------------
  nrlj_pkg::front_t fr;

  nrlj_front u_front (
    .clk     (clk),
    .en      (en),
    .pair    (pair_data),
    .chi_par (chi_par),
    .chi_per (chi_per),
    .cutoff  (cutoff),
    .front   (fr)
  );

  // ---------------------------------------------------------------------------
  // Powers of R: R^2, then R^3 and R^4, then R^7 and 6b*R^3
  // ---------------------------------------------------------------------------
  logic [nrlj_pkg::R_W-1:0]       r_dly [nrlj_pkg::MUL_LAT];
  logic [nrlj_pkg::PROD2_W-1:0]   r2_p, r3_p, r4_p, r7_p, t2_p;
  logic [nrlj_pkg::MUL_W-1:0]     r_op, r2_op, r3_op, r4_op, r_late_op, att6_op;
  logic [nrlj_pkg::ATT6_W-1:0]    att6;

  // hold R until R^2 comes out
  always_ff @(posedge clk) begin
    if (en) begin
      r_dly[0] <= fr.rsq;
      for (int k = 1; k < nrlj_pkg::MUL_LAT; k++) r_dly[k] <= r_dly[k-1];
    end
  end

  assign r_op      = (nrlj_pkg::MUL_W)'(fr.rsq);
  assign r2_op     = (nrlj_pkg::MUL_W)'(r2_p[2*nrlj_pkg::R_W-1:0]);
  assign r_late_op = (nrlj_pkg::MUL_W)'(r_dly[nrlj_pkg::MUL_LAT-1]);
  assign r3_op     = (nrlj_pkg::MUL_W)'(r3_p[3*nrlj_pkg::R_W-1:0]);
  assign r4_op     = (nrlj_pkg::MUL_W)'(r4_p[4*nrlj_pkg::R_W-1:0]);
  assign att6      = {1'b0, attractive, 2'b00} + {2'b00, attractive, 1'b0};
  assign att6_op   = (nrlj_pkg::MUL_W)'(att6);

  nrlj_mul u_mul_r2 (.clk(clk), .en(en), .a(r_op),  .b(r_op),      .p(r2_p));
  nrlj_mul u_mul_r3 (.clk(clk), .en(en), .a(r2_op), .b(r_late_op), .p(r3_p));
  nrlj_mul u_mul_r4 (.clk(clk), .en(en), .a(r2_op), .b(r2_op),     .p(r4_p));
  nrlj_mul u_mul_r7 (.clk(clk), .en(en), .a(r4_op), .b(r3_op),     .p(r7_p));
  nrlj_mul u_mul_t2 (.clk(clk), .en(en), .a(att6_op), .b(r3_op),   .p(t2_p));

  // ---------------------------------------------------------------------------
  // Difference stage: M = 12a*2^96 - 6b*R^3, kept as magnitude and sign
  // ---------------------------------------------------------------------------
  logic [nrlj_pkg::REP12_W-1:0]  rep12;
  logic [nrlj_pkg::M_W-1:0]      t1, t2;
  logic [nrlj_pkg::M_W-1:0]      m_mag;
  logic                          m_neg;

  assign rep12 = {1'b0, repulsive, 3'b000} + {2'b00, repulsive, 2'b00};
  assign t1    = (nrlj_pkg::M_W)'({rep12, {nrlj_pkg::SCALE_SH{1'b0}}});
  assign t2    = t2_p[nrlj_pkg::M_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      m_neg <= t2 > t1;
      m_mag <= (t2 > t1) ? t2 - t1 : t1 - t2;
    end
  end

  // hold the front results until M is ready
  nrlj_pkg::front_t fd [nrlj_pkg::FRONT_HOLD];

  always_ff @(posedge clk) begin
    if (en) begin
      fd[0] <= fr;
      for (int k = 1; k < nrlj_pkg::FRONT_HOLD; k++) fd[k] <= fd[k-1];
    end
  end

  // hold R^7 until the numerators are ready
  logic [nrlj_pkg::DEN_W-1:0] dd [nrlj_pkg::DEN_HOLD];

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= r7_p[nrlj_pkg::DEN_W-1:0];
      for (int k = 1; k < nrlj_pkg::DEN_HOLD; k++) dd[k] <= dd[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Result sign per lane and the flags, carried alongside the numerator multipliers and the divider
  // ---------------------------------------------------------------------------
  nrlj_pkg::front_t  fm;
  nrlj_pkg::side_t   side_in;
  nrlj_pkg::side_t   sd [nrlj_pkg::SIDE_HOLD];

  assign fm               = fd[nrlj_pkg::FRONT_HOLD-1];
  assign side_in.in_range = fm.in_range;
  assign side_in.zero     = fm.zero;
  assign side_in.neg      = fm.wneg ^ nrlj_pkg::OUTER_NEG ^ {nrlj_pkg::LANES{m_neg}};

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      for (int k = 1; k < nrlj_pkg::SIDE_HOLD; k++) sd[k] <= sd[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Numerators |w| * |M| * 2^96, one multiplier per lane
  // ---------------------------------------------------------------------------
  logic [nrlj_pkg::MUL_W-1:0]                          m_op;
  logic [nrlj_pkg::LANES-1:0][nrlj_pkg::NUM_W-1:0]     num;

  assign m_op = (nrlj_pkg::MUL_W)'(m_mag);

  for (genvar l = 0; l < nrlj_pkg::LANES; l++) begin : g_lane
    logic [nrlj_pkg::MUL_W-1:0]   w_op;
    logic [nrlj_pkg::PROD2_W-1:0] n_p;

    assign w_op = (nrlj_pkg::MUL_W)'(fm.wabs[l]);

    nrlj_mul u_mul_num (.clk(clk), .en(en), .a(w_op), .b(m_op), .p(n_p));

    assign num[l] = {n_p[nrlj_pkg::NUM_W-nrlj_pkg::SCALE_SH-1:0],
                     {nrlj_pkg::SCALE_SH{1'b0}}};
  end

  // ---------------------------------------------------------------------------
  // Division by R^7
  // ---------------------------------------------------------------------------
  logic [nrlj_pkg::LANES-1:0][nrlj_pkg::QUO_W-1:0] quo;
  logic [nrlj_pkg::LANES-1:0]                      over;

  nrlj_div u_div (
    .clk  (clk),
    .en   (en),
    .num  (num),
    .den  (dd[nrlj_pkg::DEN_HOLD-1]),
    .quo  (quo),
    .over (over)
  );

  // ---------------------------------------------------------------------------
  // Sign, saturation and the zero cases
  // ---------------------------------------------------------------------------
  nrlj_pkg::side_t                                   so;
  nrlj_pkg::out_t                                    res;
  logic [nrlj_pkg::LANES-1:0][nrlj_pkg::FORCE_W-1:0] lane_val;
  logic [nrlj_pkg::LANES-1:0]                        lane_sat;
  logic                                              active;

  assign so     = sd[nrlj_pkg::SIDE_HOLD-1];
  assign active = so.in_range & ~so.zero;

  always_comb begin
    for (int l = 0; l < nrlj_pkg::LANES; l++) begin
      if (so.neg[l]) begin
        lane_sat[l] = over[l] | (quo[l] > nrlj_pkg::NEG_MAX);
        lane_val[l] = lane_sat[l] ? nrlj_pkg::NEG_MAX : ~quo[l] + 1'b1;
      end else begin
        lane_sat[l] = over[l] | (quo[l] > nrlj_pkg::POS_MAX);
        lane_val[l] = lane_sat[l] ? nrlj_pkg::POS_MAX : quo[l];
      end
      if (!active) begin
        lane_val[l] = '0;
        lane_sat[l] = 1'b0;
      end
    end
    res.force_i_x = lane_val[0];
    res.force_i_y = lane_val[1];
    res.force_i_z = lane_val[2];
    res.force_j_x = lane_val[3];
    res.force_j_y = lane_val[4];
    res.force_j_z = lane_val[5];
    res.in_range  = so.in_range;
    res.saturated = |lane_sat;
  end

  // ---------------------------------------------------------------------------
  // Output register and skid stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      force_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      // drain the parked result once the output frees up
      if (!force_valid || !force_stall) begin
        force_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end
    end else if (pv) begin
      if (force_valid && force_stall) skid_valid  <= 1'b1;
      else                            force_valid <= 1'b1;
    end else if (!force_stall) begin
      force_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!force_valid || !force_stall) force_data <= skid_data;
    end else if (pv) begin
      if (force_valid && force_stall) skid_data  <= res;
      else                            force_data <= res;
    end
  end

endmodule

// ----- rtl/nrlj_checker.sv -----
// Port-level checker for the pair force pipeline, bound to the top level.
`timescale 1ns / 1ps
module nrlj_checker (
  input logic           clk,
  input logic           rst,
  input logic           pair_stall,
  input logic           force_valid,
  input logic           force_stall,
  input nrlj_pkg::out_t force_data
);

  // a held result does not change or vanish
  assert property (@(posedge clk) disable iff (rst)
    force_valid && force_stall |=> force_valid && $stable(force_data))
    else $error("stalled result changed");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !force_valid)
    else $error("result valid right after reset");

  // a result transfer always leaves the input open
  assert property (@(posedge clk) disable iff (rst)
    force_valid && !force_stall |=> !pair_stall)
    else $error("input stalled after output transfer");

  // out of range gives zero force and no clipping
  assert property (@(posedge clk) disable iff (rst)
    force_valid && !force_data.in_range |->
      force_data.force_i_x == '0 && force_data.force_i_y == '0 &&
      force_data.force_i_z == '0 && force_data.force_j_x == '0 &&
      force_data.force_j_y == '0 && force_data.force_j_z == '0 &&
      !force_data.saturated)
    else $error("nonzero force out of range");

  // clipping only happens on pairs in range
  assert property (@(posedge clk) disable iff (rst)
    force_valid && force_data.saturated |-> force_data.in_range)
    else $error("saturated flag on pair out of range");

endmodule

bind nonreciprocal_lj_pair_force nrlj_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pair_stall  (pair_stall),
  .force_valid (force_valid),
  .force_stall (force_stall),
  .force_data  (force_data)
);

// ----- tb/sv/nonreciprocal_lj_pair_force_test.sv -----
// Self-checking testbench for the non-reciprocal Lennard-Jones pair force pipeline.
`timescale 1ns / 1ps
module nonreciprocal_lj_pair_force_test;

  typedef logic [511:0] big_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  nrlj_pkg::in_t pair_data = '0;
  logic force_valid;
  logic force_stall = 1'b0;
  nrlj_pkg::out_t force_data;
  logic cfg_write = 1'b0;
  logic [nrlj_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nrlj_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  nonreciprocal_lj_pair_force uut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall), .pair_data(pair_data),
    .force_valid(force_valid), .force_stall(force_stall), .force_data(force_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the coefficient registers, kept in step with every write.
  logic [nrlj_pkg::COEF_W-1:0] repulsive = nrlj_pkg::REPULSIVE_RST;
  logic [nrlj_pkg::COEF_W-1:0] attractive = nrlj_pkg::ATTRACTIVE_RST;
  longint chi_par = 0;
  longint chi_per = 0;
  logic [nrlj_pkg::CUT_W-1:0] cutoff = nrlj_pkg::CUTOFF_RST;

  nrlj_pkg::in_t pending_pairs[$];
  nrlj_pkg::out_t expected_forces[$];
  logic pair_taken = 1'b0;
  bit quiet = 1'b0;          // when set, neither side idles
  int hold_request = 0;      // bumped to ask the receiver for a long hold-off
  int hold_served = 0;
  int hold_left = 0;
  int failures = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // One force lane: exact quotient, truncated toward zero, then saturated.
  function automatic logic [nrlj_pkg::FORCE_W-1:0] force_lane(longint w, bit outer_neg,
                                                              big_t base, bit m_neg,
                                                              big_t den, inout bit clipped);
    logic [63:0] mag;
    big_t q;
    bit neg;
    mag = (w < 0) ? 64'(-w) : 64'(w);
    q = (base * big_t'(mag)) / den;
    neg = ((w < 0) ^ outer_neg) ^ m_neg;
    if (neg) begin
      if (q > big_t'(nrlj_pkg::NEG_MAX)) begin
        clipped = 1'b1;
        q = big_t'(nrlj_pkg::NEG_MAX);
      end
      return -q[nrlj_pkg::FORCE_W-1:0];
    end
    if (q > big_t'(nrlj_pkg::POS_MAX)) begin
      clipped = 1'b1;
      q = big_t'(nrlj_pkg::POS_MAX);
    end
    return q[nrlj_pkg::FORCE_W-1:0];
  endfunction

  function automatic nrlj_pkg::out_t pair_forces(nrlj_pkg::in_t p);
    nrlj_pkg::out_t r;
    longint x, y, z, ip, iq, jp, jq;
    longint wi[3], wj[3];
    logic [63:0] rsq;
    big_t den, rep_term, att_term, base;
    bit m_neg, clipped;
    r = '0;
    clipped = 1'b0;
    x = longint'(p.disp_x);
    y = longint'(p.disp_y);
    z = longint'(p.disp_z);
    rsq = 64'(x * x) + 64'(y * y) + 64'(z * z);
    if (rsq >= (64'(cutoff) << nrlj_pkg::FRAC_W)) return r;
    r.in_range = 1'b1;
    if (rsq == 0) return r;
    den = big_t'(rsq);
    for (int k = 0; k < 6; k++) den = den * big_t'(rsq);
    rep_term = (big_t'(repulsive) * 12) << nrlj_pkg::SCALE_SH;
    att_term = big_t'(attractive) * 6;
    for (int k = 0; k < 3; k++) att_term = att_term * big_t'(rsq);
    m_neg = att_term > rep_term;
    base = (m_neg ? att_term - rep_term : rep_term - att_term) << nrlj_pkg::SCALE_SH;
    ip = 65536; iq = 0; jp = 65536; jq = 0;
    // Only the two special kinds break Newton's third law.
    if (p.kind_i == nrlj_pkg::KIND_A && p.kind_j == nrlj_pkg::KIND_B) begin
      ip = 65536 + chi_par; iq = chi_per;
      jp = 65536 - chi_par; jq = -chi_per;
    end else if (p.kind_i == nrlj_pkg::KIND_B && p.kind_j == nrlj_pkg::KIND_A) begin
      ip = 65536 - chi_par; iq = -chi_per;
      jp = 65536 + chi_par; jq = chi_per;
    end
    wi[0] = x * ip + y * iq; wi[1] = y * ip - x * iq; wi[2] = z * ip;
    wj[0] = x * jp + y * jq; wj[1] = y * jp - x * jq; wj[2] = z * jp;
    r.force_i_x = force_lane(wi[0], 1'b1, base, m_neg, den, clipped);
    r.force_i_y = force_lane(wi[1], 1'b1, base, m_neg, den, clipped);
    r.force_i_z = force_lane(wi[2], 1'b1, base, m_neg, den, clipped);
    r.force_j_x = force_lane(wj[0], 1'b0, base, m_neg, den, clipped);
    r.force_j_y = force_lane(wj[1], 1'b0, base, m_neg, den, clipped);
    r.force_j_z = force_lane(wj[2], 1'b0, base, m_neg, den, clipped);
    r.saturated = clipped;
    return r;
  endfunction

  // Drive the sender: advance to the next pair after a transfer, idle now and then.
  always @(negedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (!pair_valid || pair_taken) begin
      if (pending_pairs.size() > 0 &&
          (quiet || hold_left > 0 || $urandom_range(0, 99) >= 25)) begin
        pair_data <= pending_pairs.pop_front();
        pair_valid <= 1'b1;
      end else begin
        pair_valid <= 1'b0;
      end
    end
  end

  // Drive the receiver: random stalls, plus a long hold-off when requested so
  // the pipe fills and pushes back on the sender.
  always @(negedge clk) begin
    if (hold_served != hold_request) begin
      hold_served <= hold_request;
      hold_left <= 400;
      force_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      force_stall <= 1'b1;
    end else begin
      force_stall <= !quiet && ($urandom_range(0, 99) < 25);
    end
  end

  task automatic check_field(string name, logic [nrlj_pkg::FORCE_W-1:0] want,
                             logic [nrlj_pkg::FORCE_W-1:0] got);
    if (want !== got) begin
      $error("%s expected %h got %h", name, want, got);
      failures++;
    end
  endtask

  // Record each pair transfer as an expectation; check each force transfer.
  always @(posedge clk) begin
    nrlj_pkg::out_t want;
    pair_taken <= pair_valid && !pair_stall && !rst;
    if (!rst && pair_valid && !pair_stall) expected_forces.push_back(pair_forces(pair_data));
    if (!rst && force_valid && !force_stall) begin
      if (expected_forces.size() == 0) begin
        $error("force transfer with nothing expected");
        failures++;
      end else begin
        want = expected_forces.pop_front();
        check_field("force_i_x", want.force_i_x, force_data.force_i_x);
        check_field("force_i_y", want.force_i_y, force_data.force_i_y);
        check_field("force_i_z", want.force_i_z, force_data.force_i_z);
        check_field("force_j_x", want.force_j_x, force_data.force_j_x);
        check_field("force_j_y", want.force_j_y, force_data.force_j_y);
        check_field("force_j_z", want.force_j_z, force_data.force_j_z);
        check_field("in_range", (nrlj_pkg::FORCE_W)'(want.in_range),
                    (nrlj_pkg::FORCE_W)'(force_data.in_range));
        check_field("saturated", (nrlj_pkg::FORCE_W)'(want.saturated),
                    (nrlj_pkg::FORCE_W)'(force_data.saturated));
      end
    end
  end

  task automatic write_reg(nrlj_pkg::cfg_reg_t which, logic [nrlj_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    case (which)
      nrlj_pkg::REG_REPULSIVE:     repulsive = value;
      nrlj_pkg::REG_ATTRACTIVE:    attractive = value;
      nrlj_pkg::REG_PARALLEL:      chi_par = longint'($signed(value[nrlj_pkg::CHI_W-1:0]));
      nrlj_pkg::REG_PERPENDICULAR: chi_per = longint'($signed(value[nrlj_pkg::CHI_W-1:0]));
      nrlj_pkg::REG_CUTOFF:        cutoff = value[nrlj_pkg::CUT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold until every queued pair has come back, then let the pipe drain.
  task automatic drain;
    do @(posedge clk);
    while (pending_pairs.size() > 0 || pair_valid || expected_forces.size() > 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic add_pair(int x, int y, int z, int ki, int kj);
    nrlj_pkg::in_t p;
    p.disp_x = x; p.disp_y = y; p.disp_z = z;
    p.kind_i = (nrlj_pkg::KIND_W)'(ki); p.kind_j = (nrlj_pkg::KIND_W)'(kj);
    pending_pairs.push_back(p);
  endtask

  // Coordinates over all magnitudes, mostly near the interaction scale.
  function automatic logic [nrlj_pkg::DISP_W-1:0] rand_coord();
    logic [nrlj_pkg::DISP_W-1:0] v;
    v = $urandom;
    v = v >> (($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom_range(13, 17));
    return ($urandom_range(0, 1) == 0) ? -v : v;
  endfunction

  function automatic int rand_kind();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1);
  endfunction

  task automatic add_random(int count);
    repeat (count) add_pair(rand_coord(), rand_coord(), rand_coord(), rand_kind(), rand_kind());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero distance, cutoff edge, extremes, A-B, B-A and other kind pairings.
    add_pair(0, 0, 0, 0, 1);
    add_pair(163840, 0, 0, 0, 1);
    add_pair(163839, 0, 0, 0, 1);
    add_pair(0, -163839, 0, 1, 0);
    add_pair(0, 0, 65536, 2, 3);
    add_pair(1, 0, 0, 0, 1);
    add_pair(-1, 1, -1, 1, 0);
    add_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 15, 15);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    add_pair(65536, 65536, 0, 1, 1);
    add_pair(-70000, 50000, 30000, 0, 1);
    add_pair(90000, -20000, -60000, 1, 0);
    add_pair(120000, 0, -50000, 0, 15);
    add_pair(0, 74000, 0, 15, 0);
    add_random(230);
    drain();

    write_reg(nrlj_pkg::REG_REPULSIVE, 48'hffffffffffff);
    write_reg(nrlj_pkg::REG_ATTRACTIVE, 48'hffffffffffff);
    write_reg(nrlj_pkg::REG_PARALLEL, 48'(131071));
    write_reg(nrlj_pkg::REG_PERPENDICULAR, 48'(-131072));
    write_reg(nrlj_pkg::REG_CUTOFF, 48'hffffffff);
    add_pair(1, 1, 1, 0, 1);
    add_pair(32'h7fffffff, 0, 0, 1, 0);
    add_random(150);
    drain();

    // Zero cutoff: nothing is in range. Run with no idling on either side.
    quiet = 1'b1;
    write_reg(nrlj_pkg::REG_REPULSIVE, 48'h0);
    write_reg(nrlj_pkg::REG_ATTRACTIVE, 48'h0);
    write_reg(nrlj_pkg::REG_PARALLEL, 48'(-131072));
    write_reg(nrlj_pkg::REG_PERPENDICULAR, 48'(131071));
    write_reg(nrlj_pkg::REG_CUTOFF, 48'h0);
    add_pair(0, 0, 0, 0, 1);
    add_random(60);
    drain();
    quiet = 1'b0;

    write_reg(nrlj_pkg::REG_CUTOFF, 48'(409600 * 4));
    write_reg(nrlj_pkg::REG_REPULSIVE, 48'(262144));
    add_random(60);
    drain();

    // Random settings, with a long receiver hold-off to back up the pipe.
    write_reg(nrlj_pkg::REG_REPULSIVE,
              (nrlj_pkg::CFG_DATA_W)'({$urandom, $urandom} >> $urandom_range(0, 40)));
    write_reg(nrlj_pkg::REG_ATTRACTIVE,
              (nrlj_pkg::CFG_DATA_W)'({$urandom, $urandom} >> $urandom_range(0, 40)));
    write_reg(nrlj_pkg::REG_PARALLEL, 48'($urandom));
    write_reg(nrlj_pkg::REG_PERPENDICULAR, 48'($urandom));
    write_reg(nrlj_pkg::REG_CUTOFF, 48'($urandom));
    add_random(200);
    hold_request = hold_request + 1;
    drain();

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/nrlj_pkg.sv
rtl/nrlj_mul.sv
rtl/nrlj_front.sv
rtl/nrlj_div.sv
rtl/nonreciprocal_lj_pair_force.sv
rtl/nrlj_checker.sv
tb/sv/nonreciprocal_lj_pair_force_test.sv
